FILE: hdl/pts_pkg.sv
// ----------------------------------------------------------------------------
// Priority task scheduler package
// Shared widths, request codes, payload structs and controller/datapath types.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int PTS_MAX_TASKS = 16;
    localparam int PTS_REQ_W     = 2;
    localparam int PTS_PRIO_W    = 8;
    localparam int PTS_ID_W      = 4;

    typedef enum logic [PTS_REQ_W-1:0] {
        REQ_CREATE = 2'd0,
        REQ_START  = 2'd1,
        REQ_YIELD  = 2'd2
    } t_req_type;

    typedef struct packed {
        logic [PTS_REQ_W-1:0]  req_type;
        logic [PTS_PRIO_W-1:0] priority_req;
    } t_req;

    typedef struct packed {
        logic                accepted;
        logic [PTS_ID_W-1:0] task_index;
        logic [PTS_ID_W-1:0] prev_task;
        logic                switch_request;
    } t_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic exec;
        logic scan_start;
        logic scan_step;
        logic scan_finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic yield_go;
        logic scan_last;
    } t_sts;

endpackage

FILE: hdl/pts_if.sv
// ----------------------------------------------------------------------------
// Priority task scheduler channels
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface pts_req_if;
    logic          valid;
    logic          ready;
    pts_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pts_res_if;
    logic          valid;
    logic          ready;
    pts_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/pts_ctrl.sv
// ----------------------------------------------------------------------------
// Priority task scheduler controller
// Sequences accept, rotation scan and result transfer.
// ----------------------------------------------------------------------------
module pts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  pts_pkg::t_sts i_sts,
    output pts_pkg::t_cmd o_cmd
);
    import pts_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.yield_go ? ST_SCAN : ST_OUT;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.exec       = i_in_valid && !i_sts.yield_go;
                o_cmd.scan_start = i_in_valid && i_sts.yield_go;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            ST_DRAIN: begin
                o_cmd.scan_finish = 1'b1;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: hdl/pts_dp.sv
// ----------------------------------------------------------------------------
// Priority task scheduler datapath
// Priority memory, task state, rotation scan and result register.
// ----------------------------------------------------------------------------
module pts_dp #(
    parameter int MAX_TASKS = pts_pkg::PTS_MAX_TASKS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pts_pkg::t_req i_req,
    input  pts_pkg::t_cmd i_cmd,
    output pts_pkg::t_sts o_sts,
    output pts_pkg::t_res o_res
);
    import pts_pkg::*;

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    logic [PTS_PRIO_W-1:0] r_mem [MAX_TASKS];

    logic [CW-1:0]         r_total;
    logic [IW-1:0]         r_running;
    logic                  r_started;

    logic [IW-1:0]         r_pos;
    logic [CW-1:0]         r_cnt;
    logic                  r_rd_vld;
    logic [IW-1:0]         r_rd_pos;
    logic [PTS_PRIO_W-1:0] r_rd_data;
    logic [IW-1:0]         r_best;
    logic [PTS_PRIO_W-1:0] r_top;
    t_res                  r_res;

    logic [IW-1:0]         n_best;
    logic [PTS_PRIO_W-1:0] n_top;
    t_res                  n_res;
    logic                  full;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p,
                                               input logic [CW-1:0] total);
        logic [CW-1:0] inc;
        inc = CW'(p) + CW'(1);
        return (inc >= total) ? '0 : inc[IW-1:0];
    endfunction

    assign full = (r_total >= CW'(MAX_TASKS));

    assign o_sts.yield_go  = (i_req.req_type == REQ_YIELD) && r_started
                             && (r_total >= CW'(2));
    assign o_sts.scan_last = (r_cnt == r_total - CW'(1));
    assign o_res           = r_res;

    // keep the first strictly higher priority seen in rotation order
    always_comb begin
        n_top  = r_top;
        n_best = r_best;
        if (r_rd_vld && (r_rd_data > r_top)) begin
            n_top  = r_rd_data;
            n_best = r_rd_pos;
        end
    end

    // result of a request that needs no scan
    always_comb begin
        n_res = '0;
        case (i_req.req_type)
            REQ_CREATE: begin
                if (!full) begin
                    n_res.accepted   = 1'b1;
                    n_res.task_index = PTS_ID_W'(r_total);
                end
            end
            REQ_START: begin
                if (r_total != '0) begin
                    n_res.accepted       = 1'b1;
                    n_res.switch_request = 1'b1;
                end
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (i_req.req_type == REQ_CREATE) && !full) begin
            r_mem[r_total[IW-1:0]] <= i_req.priority_req;
        end
        if (i_cmd.scan_step) begin
            r_rd_data <= r_mem[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_running <= '0;
            r_started <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                if ((i_req.req_type == REQ_CREATE) && !full) begin
                    r_total <= r_total + CW'(1);
                end
                if ((i_req.req_type == REQ_START) && (r_total != '0)) begin
                    r_started <= 1'b1;
                    r_running <= '0;
                end
            end
            if (i_cmd.scan_start) begin
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rd_vld <= 1'b1;
            end else if (i_cmd.scan_finish) begin
                r_rd_vld  <= 1'b0;
                r_running <= n_best;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_pos    <= wrap_inc(r_running, r_total);
            r_cnt    <= '0;
            r_top    <= '0;
            r_best   <= r_running;
        end else if (i_cmd.scan_step) begin
            r_pos    <= wrap_inc(r_pos, r_total);
            r_cnt    <= r_cnt + CW'(1);
            r_rd_pos <= r_pos;
            r_top    <= n_top;
            r_best   <= n_best;
        end
        if (i_cmd.exec) begin
            r_res <= n_res;
        end else if (i_cmd.scan_finish) begin
            r_res <= '{accepted:       1'b1,
                       task_index:     PTS_ID_W'(n_best),
                       prev_task:      PTS_ID_W'(r_running),
                       switch_request: 1'b1};
        end
    end

endmodule

FILE: hdl/priority_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// Priority task scheduler top level
// Usage:
//   i_req carries one request per transfer: req_type (create, start, yield)
//   and priority_req for create. o_res returns exactly one result per
//   request: accepted, task_index, prev_task and switch_request.
//   Create, start, ignored yields and unused codes have their result
//   registered and valid in the cycle after the request transfers. An
//   accepted yield scans the priority memory in rotation, one entry per
//   cycle through its single read port; a drain state follows the scan.
//   One request is in flight at a time: i_req.ready is high only while the
//   block is idle, so no new request is taken until the previous result
//   has transferred.
//   When the receiver stalls, the result holds in the output register and
//   no new request is taken until it transfers.
//   Reset (i_rst_n low, synchronous) clears task count, running task and
//   started flag; priority memory contents are left as they are, since only
//   entries below the task count are ever read.
// ----------------------------------------------------------------------------
module priority_task_scheduler_top #(
    parameter int MAX_TASKS = pts_pkg::PTS_MAX_TASKS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pts_req_if.sink     i_req,
    pts_res_if.source   o_res
);
    import pts_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequence request acceptance, scan steps and result transfer
    pts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // hold task state and priorities, run the rotation scan
    pts_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req.data),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_res   (o_res.data)
    );

endmodule
